/* sv/fprf_pkg.sv */
// Shared types and codes for the framed packet receiver with Fletcher-16 check.
// Depends on nothing; every other file of the block refers to it by scoped names.
package fprf_pkg;

	localparam int ByteW = 8;
	localparam int KindW = 3;
	localparam int CfgIdxW = 2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_START_FIRST = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_START_SECOND = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH = 2'd2;

	// Result kinds
	localparam logic [KindW-1:0] KIND_PAYLOAD = 3'd0;
	localparam logic [KindW-1:0] KIND_ACCEPT = 3'd1;
	localparam logic [KindW-1:0] KIND_BADSUM = 3'd2;
	localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd3;
	localparam logic [KindW-1:0] KIND_TOOLONG = 3'd4;

	// Message ids that the block recognises
	localparam logic [ByteW-1:0] MSG_ID_ONE = 8'd1;
	localparam logic [ByteW-1:0] MSG_ID_TWO = 8'd2;

	// Fletcher-16 sums are kept modulo this value
	localparam logic [ByteW:0] FLETCHER_MOD = 9'd255;

	typedef struct packed {
		logic [ByteW-1:0] start_first;
		logic [ByteW-1:0] start_second;
		logic [ByteW-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] payload_byte;
		logic [ByteW-1:0] byte_position;
		logic [ByteW-1:0] message_id;
	} res_t;

endpackage

/* sv/fprf_deframer.sv */
// Frame hunting state machine with running Fletcher-16 sums and verdict logic.
// Depends on fprf_pkg for the configuration and result structs and the kind codes.
module fprf_deframer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [fprf_pkg::ByteW-1:0] byte_s1,
	input  fprf_pkg::cfg_t            cfg,
	output fprf_pkg::res_t            res
);

	localparam logic [2:0] PH_HUNT1 = 3'd0;
	localparam logic [2:0] PH_HUNT2 = 3'd1;
	localparam logic [2:0] PH_LEN = 3'd2;
	localparam logic [2:0] PH_ID = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_CKLO = 3'd5;
	localparam logic [2:0] PH_CKHI = 3'd6;

	logic [2:0]                phase_q, phase_d;
	logic [fprf_pkg::ByteW-1:0] length_q, length_d;
	logic [fprf_pkg::ByteW-1:0] count_q, count_d;
	logic [fprf_pkg::ByteW-1:0] id_q, id_d;
	logic [fprf_pkg::ByteW-1:0] sum_one_q, sum_one_d;
	logic [fprf_pkg::ByteW-1:0] sum_two_q, sum_two_d;
	logic [fprf_pkg::ByteW-1:0] ck_low_q, ck_low_d;

	logic [fprf_pkg::ByteW:0]   add_one, add_two;
	logic [fprf_pkg::ByteW-1:0] new_one, new_two;
	logic [fprf_pkg::ByteW-1:0] count_inc;

	// Both sums stay below 255, so each raw sum is below 510 and one
	// conditional subtract brings it back into range.
	always_comb begin
		add_one = {1'b0, sum_one_q} + {1'b0, byte_s1};
		new_one = (add_one >= fprf_pkg::FLETCHER_MOD) ?
			fprf_pkg::ByteW'(add_one - fprf_pkg::FLETCHER_MOD) : add_one[fprf_pkg::ByteW-1:0];
		add_two = {1'b0, sum_two_q} + {1'b0, new_one};
		new_two = (add_two >= fprf_pkg::FLETCHER_MOD) ?
			fprf_pkg::ByteW'(add_two - fprf_pkg::FLETCHER_MOD) : add_two[fprf_pkg::ByteW-1:0];
		count_inc = count_q + 8'd1;
	end

	always_comb begin
		phase_d = phase_q;
		length_d = length_q;
		count_d = count_q;
		id_d = id_q;
		sum_one_d = sum_one_q;
		sum_two_d = sum_two_q;
		ck_low_d = ck_low_q;
		res = '0;
		case (phase_q)
			PH_HUNT1: begin
				if (byte_s1 == cfg.start_first) phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				phase_d = (byte_s1 == cfg.start_second) ? PH_LEN : PH_HUNT1;
			end
			PH_LEN: begin
				if (byte_s1 > cfg.max_length) begin
					phase_d = PH_HUNT1;
					res.valid = 1'b1;
					res.kind = fprf_pkg::KIND_TOOLONG;
				end else begin
					length_d = byte_s1;
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				id_d = byte_s1;
				count_d = '0;
				sum_one_d = '0;
				sum_two_d = '0;
				phase_d = (length_q == '0) ? PH_CKLO : PH_DATA;
			end
			PH_DATA: begin
				sum_one_d = new_one;
				sum_two_d = new_two;
				count_d = count_inc;
				if (count_inc >= length_q) phase_d = PH_CKLO;
				res.valid = 1'b1;
				res.kind = fprf_pkg::KIND_PAYLOAD;
				res.payload_byte = byte_s1;
				res.byte_position = count_q;
				res.message_id = id_q;
			end
			PH_CKLO: begin
				ck_low_d = byte_s1;
				phase_d = PH_CKHI;
			end
			PH_CKHI: begin
				phase_d = PH_HUNT1;
				res.valid = 1'b1;
				res.message_id = id_q;
				if (ck_low_q != sum_one_q || byte_s1 != sum_two_q)
					res.kind = fprf_pkg::KIND_BADSUM;
				else if (id_q == fprf_pkg::MSG_ID_ONE || id_q == fprf_pkg::MSG_ID_TWO)
					res.kind = fprf_pkg::KIND_ACCEPT;
				else
					res.kind = fprf_pkg::KIND_UNKNOWN;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
		if (!step) res.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			length_q <= '0;
			count_q <= '0;
			id_q <= '0;
			sum_one_q <= '0;
			sum_two_q <= '0;
			ck_low_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			length_q <= length_d;
			count_q <= count_d;
			id_q <= id_d;
			sum_one_q <= sum_one_d;
			sum_two_q <= sum_two_d;
			ck_low_q <= ck_low_d;
		end
	end

	// A payload beat is only ever produced from the data phase.
	a_payload_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == fprf_pkg::KIND_PAYLOAD) |-> (phase_q == PH_DATA))
		else $error("payload result outside the data phase");

	// While payload is being counted, the count never reaches the frame length.
	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (count_q < length_q))
		else $error("payload count ran past the frame length");

	// Reduced sums never hold 255.
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_one_q != 8'hFF) && (sum_two_q != 8'hFF))
		else $error("Fletcher sum left unreduced");

endmodule

/* sv/framed_packet_receiver_fletcher16_top.sv */
// Top level of the framed serial packet receiver with Fletcher-16 verdict.
// Depends on fprf_pkg and instantiates fprf_deframer.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------------------
//   rx       | in        | rx_valid / rx_stall   | rx_byte
//   res      | out       | res_valid / res_stall | kind, payload_byte, byte_position,
//            |           |                       | message_id
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The block takes one received byte per cycle while the result output is not stalled.  A
// byte is captured in an input register, stepped through the frame state machine once the
// result register is free or being emptied and, if it causes a result, lands in the result
// register at the end of that step, from where it leaves when the consumer takes it.  Reset
// puts the block in the hunting state with the start bytes at zero and the length limit
// at 255.  A stalled result holds the state machine and the captured byte; the input
// stalls only once its register is full and cannot move on.
module framed_packet_receiver_fletcher16_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rx_valid,
	output logic                         rx_stall,
	input  logic [fprf_pkg::ByteW-1:0]   rx_byte,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [fprf_pkg::KindW-1:0]   kind,
	output logic [fprf_pkg::ByteW-1:0]   payload_byte,
	output logic [fprf_pkg::ByteW-1:0]   byte_position,
	output logic [fprf_pkg::ByteW-1:0]   message_id,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fprf_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [fprf_pkg::ByteW-1:0]   cfg_data
);

	fprf_pkg::cfg_t cfg_q;
	fprf_pkg::res_t res_c;
	fprf_pkg::res_t res_q;

	logic                       valid_s1;
	logic [fprf_pkg::ByteW-1:0] byte_s1;
	logic                       step;
	logic                       rx_take;

	// Registers are always writable; writes to the unused index are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first <= '0;
			cfg_q.start_second <= '0;
			cfg_q.max_length <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fprf_pkg::CFG_START_FIRST: cfg_q.start_first <= cfg_data;
				fprf_pkg::CFG_START_SECOND: cfg_q.start_second <= cfg_data;
				fprf_pkg::CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// The captured byte moves on whenever the result register is free or being emptied
	// this cycle; a byte that causes no result moves on under the same rule.
	assign step = valid_s1 && (!res_q.valid || !res_stall);
	assign rx_stall = valid_s1 && !step;
	assign rx_take = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) byte_s1 <= rx_byte;
	end

	fprf_deframer u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	// Result register: loads on every step, otherwise drains when the consumer takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (step) begin
			res_q <= res_c;
		end else if (!res_stall) begin
			res_q.valid <= 1'b0;
		end
	end

	assign res_valid = res_q.valid;
	assign kind = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign byte_position = res_q.byte_position;
	assign message_id = res_q.message_id;

endmodule

/* tb/tb.sv */
// Self-checking bench for framed_packet_receiver_fletcher16_top: byte stream in, frame events out.
// Depends on fprf_pkg and the block's RTL; predicts every event and compares each beat
// with it.
module tb;

	localparam int ByteW = fprf_pkg::ByteW;
	localparam int KindW = fprf_pkg::KindW;
	localparam int CfgIdxW = fprf_pkg::CfgIdxW;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 7;
	// Extra settling time after the traffic has drained, before a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int PRINT_LIMIT = 50;
	// The index after the last register; a write to it must change nothing.
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		GET_LENGTH,
		GET_ID,
		GET_PAYLOAD,
		GET_CK_LOW,
		GET_CK_HIGH
	} rx_phase_t;

	typedef struct {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] pbyte;
		logic [ByteW-1:0] pos;
		logic [ByteW-1:0] msg;
	} frame_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [ByteW-1:0] rx_byte = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [KindW-1:0] kind;
	logic [ByteW-1:0] payload_byte;
	logic [ByteW-1:0] byte_position;
	logic [ByteW-1:0] message_id;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [ByteW-1:0] cfg_data = '0;

	// Register copies, as the block holds them after reset.
	logic [ByteW-1:0] start_first = 8'h00;
	logic [ByteW-1:0] start_second = 8'h00;
	logic [ByteW-1:0] len_limit = 8'hFF;

	// Frame tracking state of the prediction.
	rx_phase_t hunt_phase = HUNT_FIRST;
	logic [ByteW-1:0] frame_len = '0;
	logic [ByteW-1:0] frame_count = '0;
	logic [ByteW-1:0] frame_msg = '0;
	logic [ByteW-1:0] sum_a = '0;
	logic [ByteW-1:0] sum_b = '0;
	logic [ByteW-1:0] ck_low = '0;

	logic [ByteW-1:0] pending_bytes[$];
	frame_event_t due_events[$];
	int bytes_queued = 0;
	int fault_count = 0;
	int results_seen = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit long_hold_req = 1'b0;
	bit calm = 1'b0;

	framed_packet_receiver_fletcher16_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.byte_position (byte_position),
		.message_id    (message_id),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The run is cut short here if the block hangs or drops a result.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb failed");
		$finish;
	end

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= PRINT_LIMIT) begin
			$display("%0t result %0d: %s", $time, results_seen, what);
		end
	endtask

	function automatic void add_event(input logic [KindW-1:0] k, input logic [ByteW-1:0] pb,
			input logic [ByteW-1:0] ps, input logic [ByteW-1:0] id);
		frame_event_t ev;
		ev.kind = k;
		ev.pbyte = pb;
		ev.pos = ps;
		ev.msg = id;
		due_events.push_back(ev);
	endfunction

	// Advances the frame tracker by one accepted byte and queues the event it causes, if any.
	function automatic void deframe_step(input logic [ByteW-1:0] b);
		logic [KindW-1:0] verdict;
		case (hunt_phase)
			HUNT_FIRST: begin
				if (b == start_first) hunt_phase = HUNT_SECOND;
			end
			// A wrong second start byte sends us back to hunting without testing it again.
			HUNT_SECOND: begin
				hunt_phase = (b == start_second) ? GET_LENGTH : HUNT_FIRST;
			end
			GET_LENGTH: begin
				if (b > len_limit) begin
					add_event(fprf_pkg::KIND_TOOLONG, '0, '0, '0);
					hunt_phase = HUNT_FIRST;
				end else begin
					frame_len = b;
					hunt_phase = GET_ID;
				end
			end
			GET_ID: begin
				frame_msg = b;
				frame_count = '0;
				sum_a = '0;
				sum_b = '0;
				hunt_phase = (frame_len == 0) ? GET_CK_LOW : GET_PAYLOAD;
			end
			GET_PAYLOAD: begin
				sum_a = ByteW'((9'(sum_a) + 9'(b)) % fprf_pkg::FLETCHER_MOD);
				sum_b = ByteW'((9'(sum_b) + 9'(sum_a)) % fprf_pkg::FLETCHER_MOD);
				add_event(fprf_pkg::KIND_PAYLOAD, b, frame_count, frame_msg);
				frame_count = frame_count + 8'd1;
				if (frame_count >= frame_len) hunt_phase = GET_CK_LOW;
			end
			GET_CK_LOW: begin
				ck_low = b;
				hunt_phase = GET_CK_HIGH;
			end
			GET_CK_HIGH: begin
				if (ck_low != sum_a || b != sum_b)
					verdict = fprf_pkg::KIND_BADSUM;
				else if (frame_msg == fprf_pkg::MSG_ID_ONE || frame_msg == fprf_pkg::MSG_ID_TWO)
					verdict = fprf_pkg::KIND_ACCEPT;
				else
					verdict = fprf_pkg::KIND_UNKNOWN;
				add_event(verdict, '0, '0, frame_msg);
				hunt_phase = HUNT_FIRST;
			end
			default: begin
				hunt_phase = HUNT_FIRST;
			end
		endcase
	endfunction

	// Sender: takes bytes from the pending queue and offers them, with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall) deframe_step(rx_byte);
			// A stalled beat stays on the port untouched.
			if (!(rx_valid && rx_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					rx_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					rx_byte <= pending_bytes.pop_front();
					rx_valid <= 1'b1;
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every result beat against the oldest predicted event and drives the
	// stall, either in short random bursts or in one long hold when asked.
	always @(posedge clk) begin : result_monitor
		frame_event_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_events.size() == 0) begin
					report_fault($sformatf("kind %0d arrived with nothing expected", kind));
				end else begin
					want = due_events.pop_front();
					if (kind !== want.kind)
						report_fault($sformatf("kind %0d, expected %0d", kind, want.kind));
					if (payload_byte !== want.pbyte)
						report_fault($sformatf("payload_byte %0h, expected %0h", payload_byte,
							want.pbyte));
					if (byte_position !== want.pos)
						report_fault($sformatf("byte_position %0d, expected %0d", byte_position,
							want.pos));
					if (message_id !== want.msg)
						report_fault($sformatf("message_id %0h, expected %0h", message_id,
							want.msg));
				end
				results_seen++;
			end
			if (long_hold_req) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic void put_byte(input logic [ByteW-1:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endfunction

	// Queues a complete frame under the current start bytes. A fill of -1 gives random
	// payload; spoil corrupts one or both checksum bytes.
	task automatic queue_frame(input int len, input logic [ByteW-1:0] id, input bit spoil,
			input int fill);
		int s1;
		int s2;
		logic [ByteW-1:0] d;
		logic [ByteW-1:0] lo;
		logic [ByteW-1:0] hi;
		s1 = 0;
		s2 = 0;
		put_byte(start_first);
		put_byte(start_second);
		put_byte(ByteW'(len));
		put_byte(id);
		for (int i = 0; i < len; i++) begin
			d = (fill < 0) ? ByteW'($urandom) : ByteW'(fill);
			s1 = (s1 + d) % 255;
			s2 = (s2 + s1) % 255;
			put_byte(d);
		end
		lo = ByteW'(s1);
		hi = ByteW'(s2);
		if (spoil) begin
			case ($urandom_range(0, 2))
				0: lo = lo ^ ByteW'($urandom_range(1, 255));
				1: hi = hi ^ ByteW'($urandom_range(1, 255));
				default: begin
					lo = lo ^ ByteW'($urandom_range(1, 255));
					hi = hi ^ ByteW'($urandom_range(1, 255));
				end
			endcase
		end
		put_byte(lo);
		put_byte(hi);
	endtask

	task automatic queue_too_long(input int len);
		put_byte(start_first);
		put_byte(start_second);
		put_byte(ByteW'(len));
	endtask

	// Random traffic: mostly well-formed frames with random content, the rest spoilt
	// checksums, oversized lengths, broken start pairs and line noise.
	task automatic queue_traffic(input int budget);
		int base;
		int r;
		int lim;
		logic [ByteW-1:0] id;
		logic [ByteW-1:0] junk;
		base = bytes_queued;
		lim = (len_limit > 24) ? 24 : int'(len_limit);
		while (bytes_queued - base < budget) begin
			r = $urandom_range(0, 9);
			id = (r < 4) ? fprf_pkg::MSG_ID_ONE : (r < 7) ? fprf_pkg::MSG_ID_TWO :
				ByteW'($urandom);
			r = $urandom_range(0, 99);
			if (r < 74 && r >= 62) begin
				queue_frame($urandom_range(0, lim), id, 1'b1, -1);
			end else if (r >= 74 && r < 84 && len_limit != 8'hFF) begin
				queue_too_long($urandom_range(int'(len_limit) + 1, 255));
			end else if (r >= 84 && r < 92) begin
				junk = ByteW'($urandom);
				if (junk == start_second) junk = junk + 8'd1;
				put_byte(start_first);
				put_byte(junk);
			end else if (r >= 92) begin
				repeat ($urandom_range(1, 4)) begin
					junk = ByteW'($urandom);
					if (junk == start_first) junk = junk ^ 8'h01;
					put_byte(junk);
				end
			end else begin
				queue_frame($urandom_range(0, lim), id, 1'b0, -1);
			end
		end
	endtask

	// Waits until every byte has gone in and every predicted event has come out, then lets
	// the pipeline settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || rx_valid || due_events.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			fprf_pkg::CFG_START_FIRST: start_first = val;
			fprf_pkg::CFG_START_SECOND: start_second = val;
			fprf_pkg::CFG_MAX_LENGTH: len_limit = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
			input logic [ByteW-1:0] limit);
		write_reg(fprf_pkg::CFG_START_FIRST, first);
		write_reg(fprf_pkg::CFG_START_SECOND, second);
		write_reg(fprf_pkg::CFG_MAX_LENGTH, limit);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: zero start bytes, limit 255, an empty frame with id two.
		queue_frame(0, fprf_pkg::MSG_ID_TWO, 1'b0, 0);
		wait_drained();

		// Directed cases under a small limit. The write past the last register must be
		// ignored.
		configure(8'hA5, 8'h5A, 8'd4);
		write_reg(CFG_UNUSED, 8'h33);
		queue_frame(0, fprf_pkg::MSG_ID_ONE, 1'b0, 0);
		queue_too_long(5);
		// The second A5 is a wrong second start byte and must not restart the hunt itself.
		put_byte(8'hA5);
		put_byte(8'hA5);
		// An all-ones payload byte folds to zero sums; id zero is unknown.
		queue_frame(1, 8'h00, 1'b0, 255);
		queue_frame(0, fprf_pkg::MSG_ID_TWO, 1'b1, 0);
		wait_drained();

		// Random traffic with one long receiver hold while bytes keep being offered, so
		// that the block fills and stalls its input.
		configure(8'h7E, 8'h81, 8'd12);
		queue_traffic(330);
		@(negedge clk) long_hold_req = 1'b1;
		wait_drained();

		// All-ones start bytes and a zero limit: only empty frames get through.
		configure(8'hFF, 8'hFF, 8'd0);
		queue_traffic(200);
		wait_drained();

		// Full limit, including one frame of the largest length.
		configure(8'h00, 8'hFF, 8'hFF);
		queue_traffic(120);
		queue_frame(255, fprf_pkg::MSG_ID_ONE, 1'b0, -1);
		queue_traffic(130);
		wait_drained();

		configure(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom_range(1, 30)));
		queue_traffic(250);
		wait_drained();

		// Closing stretch with neither side idling.
		calm = 1'b1;
		configure(ByteW'($urandom), ByteW'($urandom), 8'd20);
		queue_traffic(230);
		wait_drained();

		repeat (8) @(negedge clk);
		if (fault_count == 0 && due_events.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

/* framed_packet_receiver_fletcher16_top.f */
sv/fprf_pkg.sv
sv/fprf_deframer.sv
sv/framed_packet_receiver_fletcher16_top.sv
tb/tb.sv
